FILE: hdl/vertex_triple_dedup_macros.svh
// Assertion macros for the vertex triple dedup block.
// Used by vdd_search_ctrl; no other dependencies.
`ifndef VERTEX_TRIPLE_DEDUP_MACROS_SVH
`define VERTEX_TRIPLE_DEDUP_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge out of reset.
`define VDD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("vdd assertion failed");

// Antecedent in this cycle implies consequent in the next.
`define VDD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vdd assertion failed");

`else

`define VDD_ASSERT(lbl, clk, rstn, prop)
`define VDD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/vdd_pkg.sv
// Shared types and constants for the vertex triple dedup block.
// No dependencies.
package vdd_pkg;

    localparam int KEY_W = 25;
    localparam int IDX_W = 24;

    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    typedef struct packed {
        logic [KEY_W-1:0] pos;
        logic [KEY_W-1:0] normal;
        logic [KEY_W-1:0] uv;
    } key_t;

    typedef struct packed {
        key_t             key;
        logic [IDX_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic             is_new;
        logic             overflow;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MISS,
        ST_HOLD
    } state_t;

endpackage

FILE: hdl/vdd_table_ram.sv
// Triple table storage: one write port, one registered read port.
// Depends on vdd_pkg.
module vdd_table_ram #(
    parameter int TABLE_DEPTH = 64,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  vdd_pkg::entry_t  wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output vdd_pkg::entry_t  rd_data
);
    import vdd_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/vdd_search_ctrl.sv
// Search sequencer: scans the table one entry per cycle, inserts on miss unless the
// table is full, holds the result until taken. Depends on vdd_pkg and the macros header.
module vdd_search_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int AW          = $clog2(TABLE_DEPTH),
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_first,
    input  vdd_pkg::key_t    in_key,
    output logic             res_valid,
    input  logic             res_ready,
    output vdd_pkg::result_t res,
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output vdd_pkg::entry_t  wr_data,
    output logic             rd_en,
    output logic [AW-1:0]    rd_addr,
    input  vdd_pkg::entry_t  rd_data
);
    import vdd_pkg::*;

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    state_t           state_reg, state_next;
    key_t             key_reg, key_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic             rdv_reg, rdv_next;
    logic [IDX_W-1:0] nidx_reg, nidx_next;
    result_t          res_reg, res_next;
    logic [CW-1:0]    cnt_eff;
    logic             match;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            rdv_reg   <= 1'b0;
            nidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            rdv_reg   <= rdv_next;
            nidx_reg  <= nidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        res_reg <= res_next;
    end

    assign match = rdv_reg && (rd_data.key == key_reg);

    always_comb begin
        state_next = state_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        rdv_next   = rdv_reg;
        nidx_next  = nidx_reg;
        res_next   = res_reg;
        cnt_eff    = cnt_reg;
        wr_en      = 1'b0;
        wr_addr    = cnt_reg[AW-1:0];
        wr_data    = '{key: key_reg, value: nidx_reg};
        rd_en      = 1'b0;
        rd_addr    = ptr_reg[AW-1:0];
        in_ready   = (state_reg == ST_IDLE);
        res_valid  = (state_reg == ST_HOLD);

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    key_next = in_key;
                    cnt_eff  = in_first ? '0 : cnt_reg;
                    cnt_next = cnt_eff;
                    ptr_next = '0;
                    rdv_next = 1'b0;
                    state_next = (cnt_eff == '0) ? ST_MISS : ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_en    = (ptr_reg != cnt_reg);
                rdv_next = rd_en;
                if (rd_en) begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (match) begin
                    res_next   = '{out_index: rd_data.value, is_new: 1'b0, overflow: 1'b0};
                    rdv_next   = 1'b0;
                    state_next = ST_HOLD;
                end else if (rdv_reg && !rd_en) begin
                    rdv_next   = 1'b0;
                    state_next = ST_MISS;
                end
            end
            ST_MISS: begin
                if (cnt_reg == DEPTH_C) begin
                    res_next = '{out_index: '0, is_new: 1'b0, overflow: 1'b1};
                end else begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    res_next = '{out_index: nidx_reg, is_new: 1'b1, overflow: 1'b0};
                    if (nidx_reg != IDX_MAX) begin
                        nidx_next = nidx_reg + 1'b1;
                    end
                end
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

`include "vertex_triple_dedup_macros.svh"

    `VDD_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= DEPTH_C)
    `VDD_ASSERT(a_ptr_bound, aclk, aresetn, ptr_reg <= cnt_reg)
    `VDD_ASSERT(a_wr_miss, aclk, aresetn, !wr_en || (state_reg == ST_MISS && cnt_reg != DEPTH_C))
    `VDD_ASSERT_NEXT(a_wr_grows, aclk, aresetn, wr_en, cnt_reg == $past(cnt_reg) + 1'b1)
    `VDD_ASSERT_NEXT(a_hold_rel, aclk, aresetn, state_reg == ST_HOLD && res_ready, state_reg == ST_IDLE)

endmodule

FILE: hdl/vertex_triple_dedup.sv
// Flow: an accepted corner is compared against the table entries in order; a hit
// returns the stored index, a miss appends a new entry (or flags overflow when the
// table is full). The table's single read port scans one entry per cycle, and no
// new corner is taken until the previous result has passed to the output register.
// Reset (aresetn low, synchronous): clears sequencer, entry count and index
// counter; table contents are not cleared and need no clearing pass.
module vertex_triple_dedup #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_first_of_shape,
    input  logic signed [vdd_pkg::KEY_W-1:0]    s_pos_index,
    input  logic signed [vdd_pkg::KEY_W-1:0]    s_normal_index,
    input  logic signed [vdd_pkg::KEY_W-1:0]    s_uv_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [vdd_pkg::IDX_W-1:0]           m_out_index,
    output logic                                m_is_new,
    output logic                                m_overflow
);
    import vdd_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    key_t          in_key;
    logic          res_valid;
    logic          res_ready;
    result_t       res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          m_valid_reg;
    result_t       out_reg;

    assign in_key = '{pos: s_pos_index, normal: s_normal_index, uv: s_uv_index};

    vdd_search_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_first  (s_first_of_shape),
        .in_key    (in_key),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    vdd_table_ram #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_index = out_reg.out_index;
    assign m_is_new    = out_reg.is_new;
    assign m_overflow  = out_reg.overflow;

endmodule
